[hw/rtl/cba_pkg.sv]
// Package for the contiguous block allocator.
// Holds the pool size, the request and result item types and the status codes.
// No dependencies.
package cba_pkg;

    localparam int POOL_BLOCKS = 128;
    localparam int POS_W       = $clog2(POOL_BLOCKS);
    localparam int CNT_W       = 8;
    localparam int START_W     = 7;
    localparam int FREE_W      = 8;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic             action;
        logic [CNT_W-1:0] block_count;
        logic [CNT_W-1:0] block_index;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [START_W-1:0] start_index;
        logic [FREE_W-1:0]  free_count;
    } t_rsp;

endpackage

[hw/rtl/contiguous_block_allocator.sv]
// Top level of the contiguous block allocator: a first-fit allocator over a bitmap.
// The bitmap is a rotating shift register examined one bit per cycle.
// Depends on cba_pkg.
// A free, or an allocate that finds no run, makes one pass of the bitmap.
// An allocate that fits makes two passes: one pass to find the run and one pass to mark it.
// A rejected request (bad count or index) answers in the cycle after acceptance.
// Busy stays high until the result strobe; the next item is taken from that cycle on.
// Synchronous reset frees every block and sets the free count to the pool size.
module contiguous_block_allocator
    import cba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MARK = 2'd2;
    localparam logic [1:0] S_FREE = 2'd3;

    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(POOL_BLOCKS - 1);
    localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_BLOCKS);
    localparam logic [FREE_W-1:0] POOL_FREE = FREE_W'(POOL_BLOCKS);

    logic [1:0]             r_state, n_state;
    logic [POOL_BLOCKS-1:0] r_map, n_map;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [CNT_W-1:0]       r_run, n_run;
    logic                   r_found, n_found;
    logic [POS_W-1:0]       r_first, n_first;
    logic [POS_W-1:0]       r_last, n_last;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [POS_W-1:0]       r_index, n_index;
    logic [FREE_W-1:0]      r_free, n_free;
    logic                   r_done, n_done;
    t_rsp                   r_rsp, n_rsp;

    logic                   bit_now;
    logic                   bit_out;
    logic [CNT_W-1:0]       run_inc;
    logic                   in_run;

    assign bit_now = r_map[0];
    assign run_inc = r_run + CNT_W'(1);
    assign in_run  = (r_pos >= r_first) && (r_pos <= r_last);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_run   = r_run;
        n_found = r_found;
        n_first = r_first;
        n_last  = r_last;
        n_count = r_count;
        n_index = r_index;
        n_free  = r_free;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        bit_out = bit_now;
        n_map   = r_map;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_pos   = '0;
                    n_run   = '0;
                    n_found = 1'b0;
                    n_count = i_req.block_count;
                    n_index = i_req.block_index[POS_W-1:0];
                    n_rsp.start_index = '0;
                    n_rsp.free_count  = r_free;
                    if (i_req.action == ACT_ALLOC) begin
                        if (i_req.block_count == '0 || i_req.block_count > POOL_CNT) begin
                            n_rsp.status = ST_NO_FIT;
                            n_done       = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (i_req.block_index >= POOL_CNT) begin
                            n_rsp.status = ST_BAD_INDEX;
                            n_done       = 1'b1;
                        end else begin
                            n_state = S_FREE;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_map = {bit_now, r_map[POOL_BLOCKS-1:1]};
                n_pos = r_pos + POS_W'(1);
                if (!r_found) begin
                    if (bit_now) begin
                        n_run = '0;
                    end else begin
                        n_run = run_inc;
                        if (run_inc == r_count) begin
                            n_found = 1'b1;
                            n_first = r_pos + POS_W'(1) - r_count[POS_W-1:0];
                            n_last  = r_pos;
                        end
                    end
                end
                if (r_pos == POS_LAST) begin
                    if (n_found) begin
                        n_state = S_MARK;
                    end else begin
                        n_state           = S_IDLE;
                        n_rsp.status      = ST_NO_FIT;
                        n_rsp.start_index = '0;
                        n_rsp.free_count  = r_free;
                        n_done            = 1'b1;
                    end
                end
            end
            S_MARK: begin
                bit_out = bit_now | in_run;
                n_map   = {bit_out, r_map[POOL_BLOCKS-1:1]};
                n_pos   = r_pos + POS_W'(1);
                if (r_pos == POS_LAST) begin
                    n_state           = S_IDLE;
                    n_free            = r_free - r_count;
                    n_rsp.status      = ST_OK;
                    n_rsp.start_index = START_W'(r_first);
                    n_rsp.free_count  = n_free;
                    n_done            = 1'b1;
                end
            end
            S_FREE: begin
                if (r_pos == r_index) begin
                    bit_out = 1'b0;
                    if (bit_now) begin
                        n_free = r_free + FREE_W'(1);
                    end
                end
                n_map = {bit_out, r_map[POOL_BLOCKS-1:1]};
                n_pos = r_pos + POS_W'(1);
                if (r_pos == POS_LAST) begin
                    n_state           = S_IDLE;
                    n_rsp.status      = ST_OK;
                    n_rsp.start_index = '0;
                    n_rsp.free_count  = n_free;
                    n_done            = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_map   <= '0;
            r_free  <= POOL_FREE;
            r_done  <= 1'b0;
            r_pos   <= '0;
            r_run   <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_map   <= n_map;
            r_free  <= n_free;
            r_done  <= n_done;
            r_pos   <= n_pos;
            r_run   <= n_run;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_last  <= n_last;
        r_count <= n_count;
        r_index <= n_index;
        r_rsp   <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
